### hdl/cd_pkg.sv
// Shared types and constants for the circular deque.
// Used by cd_cell, cd_chain and circular_deque; depends on nothing else.
`timescale 1ns / 1ps

package cd_pkg;

   // Default number of words the deque holds.
   localparam int CAPACITY_DEF = 16;

   // Width of one stored word.
   localparam int WORD_W = 32;

   // Request codes carried on the input channel's tuser.
   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_REAR  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_REAR   = 2'd3
   } cd_op_type;

   // Outcome codes carried on the result channel's tuser.
   typedef enum logic [1:0] {
      ST_DONE       = 2'd0,
      ST_FULL       = 2'd1,
      ST_EMPTY      = 2'd2,
      ST_UNUSED     = 2'd3
   } cd_status_type;

   // What every cell of a chain does at the next edge.
   typedef enum logic [1:0] {
      ACT_HOLD       = 2'd0,
      ACT_SHIFT_UP   = 2'd1,
      ACT_SHIFT_DOWN = 2'd2,
      ACT_WRITE_AT   = 2'd3
   } cd_act_type;

   // Command that steers one chain of cells.
   typedef struct packed {
      cd_act_type          act;
      logic [WORD_W-1:0]   data;
   } cd_chain_cmd_type;

endpackage

### hdl/cd_cell.sv
// One storage cell of a deque chain: holds a word and takes it from a
// neighbor, from the new word, or keeps it. Depends on cd_pkg.
`timescale 1ns / 1ps

module cd_cell (
   input  logic                    clock,
   input  cd_pkg::cd_act_type      act,
   input  logic                    hit,
   input  logic [cd_pkg::WORD_W-1:0] lower_data,
   input  logic [cd_pkg::WORD_W-1:0] upper_data,
   input  logic [cd_pkg::WORD_W-1:0] new_data,
   output logic [cd_pkg::WORD_W-1:0] word
);
   import cd_pkg::*;

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   // Pick the next content from the neighbors or the new word.
   always_comb begin
      word_in = word_ff;
      case (act)
         ACT_HOLD:       word_in = word_ff;
         ACT_SHIFT_UP:   word_in = lower_data;
         ACT_SHIFT_DOWN: word_in = upper_data;
         ACT_WRITE_AT:   word_in = hit ? new_data : word_ff;
         default:        word_in = word_ff;
      endcase
   end

   // Payload register, no reset needed.
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

### hdl/cd_chain.sv
// A row of cd_cell instances that together hold the deque in one order,
// with position 0 at the near end. Depends on cd_pkg and cd_cell.
`timescale 1ns / 1ps

module cd_chain #(
   parameter int CAPACITY = cd_pkg::CAPACITY_DEF,
   parameter int PW       = $clog2(CAPACITY)
) (
   input  logic                      clock,
   input  cd_pkg::cd_chain_cmd_type  cmd,
   input  logic [PW-1:0]             pos,
   output logic [cd_pkg::WORD_W-1:0] first_word,
   output logic [cd_pkg::WORD_W-1:0] second_word
);
   import cd_pkg::*;

   logic [WORD_W-1:0] words [CAPACITY];

   // Cells see both neighbors and the new word; the near end is fed with
   // the new word and the far end keeps its own value on a downward shift.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [WORD_W-1:0] lower_w;
      logic [WORD_W-1:0] upper_w;

      if (i == 0) begin : g_near
         assign lower_w = cmd.data;
      end else begin : g_mid_low
         assign lower_w = words[i-1];
      end

      if (i == CAPACITY - 1) begin : g_far
         assign upper_w = words[i];
      end else begin : g_mid_high
         assign upper_w = words[i+1];
      end

      cd_cell u_cell (
         .clock      (clock),
         .act        (cmd.act),
         .hit        (pos == PW'(i)),
         .lower_data (lower_w),
         .upper_data (upper_w),
         .new_data   (cmd.data),
         .word       (words[i])
      );
   end

   assign first_word  = words[0];
   assign second_word = words[1];

endmodule

### hdl/circular_deque.sv
// Top level of the fixed-capacity double-ended queue.
// Depends on cd_pkg and cd_chain (which uses cd_cell).
//
//   channel | dir | tdata                                   | tuser
//   --------+-----+-----------------------------------------+-------------
//   req_    | in  | value                                   | op
//   rsp_    | out | removed_value, front_value, rear_value, | status
//           |     | count, is_empty, is_full, zero pad      |
//
// A request beat is accepted whenever the result
// register is free or is being emptied in the same cycle, so one beat per
// clock is sustained while the result side keeps taking beats. Two chains
// of cells hold the contents, one with the front word at position 0 and
// one with the rear word at position 0, so both ends are always at hand.
// A synchronous reset empties the deque; cell contents are left as they are.
// A stall on the result side holds the result and stops further requests.
`timescale 1ns / 1ps

module circular_deque #(
   parameter int CAPACITY = cd_pkg::CAPACITY_DEF,
   parameter int CW       = $clog2(CAPACITY + 1),
   parameter int RSP_W    = ((3 * cd_pkg::WORD_W + CW + 2 + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [cd_pkg::WORD_W-1:0] req_tdata,  // value
   input  logic [1:0]                req_tuser,  // op
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_W-1:0]          rsp_tdata,  // removed_value, front_value,
                                                 // rear_value, count, is_empty,
                                                 // is_full, zero pad
   output logic [1:0]                rsp_tuser   // status
);
   import cd_pkg::*;

   localparam int PW   = $clog2(CAPACITY);
   localparam int USED = 3 * WORD_W + CW + 2;

   logic              accept;
   cd_op_type         op;
   cd_status_type     status;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   logic              full;
   logic              empty;
   logic [WORD_W-1:0] removed;
   logic [WORD_W-1:0] front_next;
   logic [WORD_W-1:0] rear_next;
   logic [WORD_W-1:0] f_first;
   logic [WORD_W-1:0] f_second;
   logic [WORD_W-1:0] r_first;
   logic [WORD_W-1:0] r_second;
   cd_chain_cmd_type  f_cmd;
   cd_chain_cmd_type  r_cmd;

   logic              rsp_valid_ff;
   logic [USED-1:0]   rsp_data_ff;
   logic [USED-1:0]   rsp_data_in;
   logic [1:0]        rsp_user_ff;

   assign op         = cd_op_type'(req_tuser);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == CW'(CAPACITY));
   assign empty      = (count_ff == '0);

   // Decode the request into chain commands, the outcome and the new count.
   always_comb begin
      f_cmd.act  = ACT_HOLD;
      f_cmd.data = req_tdata;
      r_cmd.act  = ACT_HOLD;
      r_cmd.data = req_tdata;
      status     = ST_DONE;
      removed    = '0;
      count_in   = count_ff;
      front_next = f_first;
      rear_next  = r_first;
      case (op)
         OP_PUSH_FRONT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               f_cmd.act  = ACT_SHIFT_UP;
               r_cmd.act  = ACT_WRITE_AT;
               count_in   = count_ff + CW'(1);
               front_next = req_tdata;
               rear_next  = empty ? req_tdata : r_first;
            end
         end
         OP_PUSH_REAR: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               f_cmd.act  = ACT_WRITE_AT;
               r_cmd.act  = ACT_SHIFT_UP;
               count_in   = count_ff + CW'(1);
               front_next = empty ? req_tdata : f_first;
               rear_next  = req_tdata;
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               f_cmd.act  = ACT_SHIFT_DOWN;
               removed    = f_first;
               count_in   = count_ff - CW'(1);
               front_next = f_second;
            end
         end
         OP_POP_REAR: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               r_cmd.act  = ACT_SHIFT_DOWN;
               removed    = r_first;
               count_in   = count_ff - CW'(1);
               rear_next  = r_second;
            end
         end
         default: begin
            status = ST_DONE;
         end
      endcase

      // Nothing moves unless a beat is taken.
      if (!accept) begin
         f_cmd.act = ACT_HOLD;
         r_cmd.act = ACT_HOLD;
      end
   end

   // Front-ordered and rear-ordered chains.
   cd_chain #(
      .CAPACITY (CAPACITY),
      .PW       (PW)
   ) u_front_chain (
      .clock       (clock),
      .cmd         (f_cmd),
      .pos         (count_ff[PW-1:0]),
      .first_word  (f_first),
      .second_word (f_second)
   );

   cd_chain #(
      .CAPACITY (CAPACITY),
      .PW       (PW)
   ) u_rear_chain (
      .clock       (clock),
      .cmd         (r_cmd),
      .pos         (count_ff[PW-1:0]),
      .first_word  (r_first),
      .second_word (r_second)
   );

   // Pack the result fields, zeroing both ends when the deque is empty.
   always_comb begin
      rsp_data_in = {
         (count_in == CW'(CAPACITY)),
         (count_in == '0),
         count_in,
         (count_in == '0) ? '0 : rear_next,
         (count_in == '0) ? '0 : front_next,
         removed
      };
   end

   // Element count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);
   assign rsp_tuser  = rsp_user_ff;

endmodule
